[rtl/smf_pkg.sv]
// Package for the sliding median filter: window size, widths and shared types.
// Used by the window front end, the sort cells, the top level and the checker.
// No dependencies.
package smf_pkg;

  // Window size (odd) and derived counts
  localparam int WIDTH       = 5;
  localparam int HALF        = WIDTH / 2;
  localparam int SAMPLE_BITS = 24;
  localparam int TDATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;

  // Per-stream sample counter, saturating
  localparam int CNT_BITS = 5;
  localparam int SEEN_MAX = (1 << CNT_BITS) - 1;

  // Tap index, flush job index and signed offset arithmetic widths
  localparam int TAP_BITS = $clog2(WIDTH);
  localparam int IDX_BITS = $clog2(HALF + 1);
  localparam int Q_BITS   = CNT_BITS + 2;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef sample_t [WIDTH-1:0]    win_t;

  // Side info that travels with each window through the sorter
  typedef struct packed {
    logic last;
    logic short_s;
  } tag_t;

endpackage

[rtl/smf_window.sv]
// Window front end: tap line of recent samples, per-stream count and the
// job generator that feeds a job register one padded window per free cycle.
// Depends on smf_pkg.
module smf_window import smf_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    pad_sel,
  input  logic    in_valid,
  output logic    in_ready,
  input  sample_t in_sample,
  input  logic    in_last,
  output logic    job_valid,
  input  logic    job_ready,
  output win_t    job_win,
  output tag_t    job_tag
);

  // Tap line: tap_r[b] is the sample b positions back from the newest
  sample_t tap_r [WIDTH];

  logic [CNT_BITS-1:0] seen_r, seen_nxt;

  // Captured item context for the job generator
  logic                gen_v_r;
  logic [CNT_BITS-1:0] c_r;
  logic                last_r;
  logic                short_r;
  logic                mirror_r;
  logic [IDX_BITS-1:0] idx_r;

  logic                job_v_r;
  win_t                job_win_r, job_win_nxt;
  tag_t                job_tag_r;

  logic                in_acc;
  logic                in_short;
  logic                has_job;
  logic                gen_last_job;
  logic                job_free;
  logic                gen_adv;
  logic                gen_done;
  logic [IDX_BITS-1:0] d;

  // Handshake between generator, input and job register
  assign in_acc   = in_valid && in_ready;
  assign in_short = in_last && (seen_r < CNT_BITS'(HALF));
  assign has_job  = last_r || (c_r >= CNT_BITS'(HALF));
  assign job_free = !job_v_r || job_ready;
  assign gen_adv  = gen_v_r && (!has_job || job_free);
  assign gen_done = gen_adv && gen_last_job;
  assign in_ready = !gen_v_r || gen_done;

  // Distance of the job's center behind the newest sample, and final-job test
  always_comb begin
    if (!last_r) begin
      d            = IDX_BITS'(HALF);
      gen_last_job = 1'b1;
    end else if (short_r) begin
      d            = c_r[IDX_BITS-1:0] - idx_r;
      gen_last_job = (idx_r == c_r[IDX_BITS-1:0]);
    end else begin
      d            = IDX_BITS'(HALF) - idx_r;
      gen_last_job = (idx_r == IDX_BITS'(HALF));
    end
  end

  // Per window slot: offset back from newest, then left and right padding
  always_comb begin : sel_taps
    logic signed [Q_BITS-1:0] cq;
    logic signed [Q_BITS-1:0] dq;
    logic signed [Q_BITS-1:0] q;
    cq = Q_BITS'(c_r);
    dq = Q_BITS'(d);
    q  = '0;
    job_win_nxt = job_win_r;
    for (int j = 0; j < WIDTH; j++) begin
      q = dq + Q_BITS'(HALF) - Q_BITS'(j);
      // before the stream start
      if (q > cq) begin
        q = mirror_r ? (cq + cq - q) : cq;
      end
      // past the last sample
      if (last_r && q[Q_BITS-1]) begin
        q = mirror_r ? -q : '0;
      end
      job_win_nxt[j] = tap_r[q[TAP_BITS-1:0]];
    end
  end

  // Saturating sample count, cleared by the last word
  always_comb begin
    if (in_last) begin
      seen_nxt = '0;
    end else if (seen_r == CNT_BITS'(SEEN_MAX)) begin
      seen_nxt = seen_r;
    end else begin
      seen_nxt = seen_r + 1'b1;
    end
  end

  // Tap line shift
  always_ff @(posedge clk) begin
    if (in_acc) begin
      tap_r[0] <= in_sample;
      for (int b = 1; b < WIDTH; b++) begin
        tap_r[b] <= tap_r[b-1];
      end
    end
  end

  // Count and generator control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r  <= '0;
      gen_v_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      if (in_acc) begin
        seen_r  <= seen_nxt;
        gen_v_r <= 1'b1;
        idx_r   <= '0;
      end else if (gen_done) begin
        gen_v_r <= 1'b0;
      end else if (gen_adv) begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  // Item context, captured on accept
  always_ff @(posedge clk) begin
    if (in_acc) begin
      c_r      <= seen_r;
      last_r   <= in_last;
      short_r  <= in_short;
      mirror_r <= pad_sel && !in_short;
    end
  end

  // Job register feeding the sorter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_v_r <= 1'b0;
    end else if (gen_adv && has_job) begin
      job_v_r <= 1'b1;
    end else if (job_ready) begin
      job_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (gen_adv && has_job) begin
      job_win_r         <= job_win_nxt;
      job_tag_r.last    <= last_r && gen_last_job;
      job_tag_r.short_s <= short_r;
    end
  end

  assign job_valid = job_v_r;
  assign job_win   = job_win_r;
  assign job_tag   = job_tag_r;

endmodule

[rtl/smf_sort_cell.sv]
// One round of an odd-even transposition sorter: compare-exchange on
// alternate neighbor pairs, registered, with valid/ready flow control.
// Depends on smf_pkg.
module smf_sort_cell import smf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic phase,
  input  logic in_valid,
  output logic in_ready,
  input  win_t in_win,
  input  tag_t in_tag,
  output logic out_valid,
  input  logic out_ready,
  output win_t out_win,
  output tag_t out_tag
);

  logic v_r;
  win_t win_r, win_nxt;
  tag_t tag_r;

  assign in_ready = !v_r || out_ready;

  // Pairs starting at even or odd slots, by phase; pairs do not overlap
  always_comb begin
    win_nxt = in_win;
    for (int i = 0; i < WIDTH - 1; i++) begin
      if ((1'(i) == phase) && ($signed(in_win[i]) > $signed(in_win[i+1]))) begin
        win_nxt[i]   = in_win[i+1];
        win_nxt[i+1] = in_win[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      win_r <= win_nxt;
      tag_r <= in_tag;
    end
  end

  assign out_valid = v_r;
  assign out_win   = win_r;
  assign out_tag   = tag_r;

endmodule

[rtl/sliding_median_filter_padded_top.sv]
// Sliding median filter, top level: config register, window front end and a
// chain of sort cells whose last stage is the output register.
// Depends on smf_pkg, smf_window and smf_sort_cell.
//
// Takes one signed sample per ready cycle and returns, per position, the
// median of a 5-wide window; the first words of a stream come out once two
// more samples have arrived, and the word marked tlast flushes the rest with
// edge padding (pad mode 0 clamps to the edge sample, 1 mirrors about it).
// Streams of one or two samples are always clamped and flagged in tuser.
// Rate: one input word per cycle unless the output stalls; a tlast word holds
// in_tready low while its flush windows go out (two extra windows for normal
// streams, up to one for short ones), as the job generator issues one window
// per cycle while the job register is free. A window passes the item context
// register, the job register and a register per round of the 5-round odd-even
// transposition sorter. pad mode is sampled when each word is accepted.
module sliding_median_filter_padded_top import smf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic                  cfg_wr_data,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [TDATA_BITS-1:0] in_tdata,   // [23:0] sample
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [TDATA_BITS-1:0] out_tdata,  // [23:0] median
  output logic                  out_tlast,
  output logic                  out_tuser   // [0] short_stream
);

  logic pad_sel_r;

  // Chain links: link 0 is the job register, link WIDTH the output register
  logic [WIDTH:0] cv;
  logic [WIDTH:0] cr;
  win_t           cw [WIDTH+1];
  tag_t           ct [WIDTH+1];

  // Pad mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pad_sel_r <= 1'b0;
    end else if (cfg_wr_en) begin
      pad_sel_r <= cfg_wr_data;
    end
  end

  smf_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .pad_sel   (pad_sel_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_sample (in_tdata[SAMPLE_BITS-1:0]),
    .in_last   (in_tlast),
    .job_valid (cv[0]),
    .job_ready (cr[0]),
    .job_win   (cw[0]),
    .job_tag   (ct[0])
  );

  // Sorter: WIDTH rounds of alternating phase
  for (genvar k = 0; k < WIDTH; k++) begin : g_cell
    smf_sort_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .phase     (1'(k)),
      .in_valid  (cv[k]),
      .in_ready  (cr[k]),
      .in_win    (cw[k]),
      .in_tag    (ct[k]),
      .out_valid (cv[k+1]),
      .out_ready (cr[k+1]),
      .out_win   (cw[k+1]),
      .out_tag   (ct[k+1])
    );
  end

  // Output word: middle of the sorted window
  assign cr[WIDTH]  = out_tready;
  assign out_tvalid = cv[WIDTH];
  assign out_tdata  = TDATA_BITS'(cw[WIDTH][HALF]);
  assign out_tlast  = ct[WIDTH].last;
  assign out_tuser  = ct[WIDTH].short_s;

endmodule

[rtl/smf_checker.sv]
// Port-level checker for the sliding median filter, bound to the top level.
// Depends on smf_pkg and sliding_median_filter_padded_top.
module smf_checker import smf_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  in_tlast,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [TDATA_BITS-1:0] out_tdata,
  input logic                  out_tlast,
  input logic                  out_tuser
);

  // Reset leaves no word pending and the input open
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> in_tready && !out_tvalid)
    else $error("block not idle after reset");

  // A stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser))
    else $error("stalled output word changed");

  // A tlast word right after a word of the same stream flushes at least two
  // windows, so the input must close in the next cycle
  a_flush_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(in_tvalid && in_tready && !in_tlast) &&
      in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("input accepted during end-of-stream flush");

endmodule

bind sliding_median_filter_padded_top smf_checker u_smf_checker (.*);
